// ===== src/pcpa_pkg.sv =====
package pcpa_pkg;

  // fixed field widths
  localparam int ADDR_W   = 32;
  localparam int STATUS_W = 2;
  localparam int CPU_F_W  = 3;
  localparam int ALU_W    = 32;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OOM = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD = 2'd2;

  // request actions
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // register indexes
  localparam logic CFG_LOW_LIMIT  = 1'b0;
  localparam logic CFG_HIGH_LIMIT = 1'b1;

  // register reset values
  localparam logic [ADDR_W-1:0] LOW_LIMIT_RST  = 32'h8000_0000;
  localparam logic [ADDR_W-1:0] HIGH_LIMIT_RST = 32'h8800_0000;

  // shared subtractor result
  typedef struct packed {
    logic [ALU_W-1:0] diff;
    logic             lt;
  } alu_res_t;

endpackage

// ===== src/pcpa_if.sv =====
interface pcpa_req_if import pcpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [CPU_F_W-1:0] cpu;
  logic [ADDR_W-1:0] page_addr;

  modport source (output valid, action, cpu, page_addr, input ready);
  modport sink   (input valid, action, cpu, page_addr, output ready);
endinterface

interface pcpa_rsp_if import pcpa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   alloc_addr;
  logic [STATUS_W-1:0] status;
  logic [CPU_F_W-1:0]  source_cpu;

  modport source (output valid, alloc_addr, status, source_cpu, input ready);
  modport sink   (input valid, alloc_addr, status, source_cpu, output ready);
endinterface

interface pcpa_cfg_if import pcpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              index;
  logic [ADDR_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/pcpa_alu.sv =====
module pcpa_alu import pcpa_pkg::*; (
  input  logic [ALU_W-1:0] opa,
  input  logic [ALU_W-1:0] opb,
  output alu_res_t         res
);

  logic [ALU_W:0] full;

  // one subtractor serves every compare and the final modulo subtract
  assign full     = {1'b0, opa} - {1'b0, opb};
  assign res.diff = full[ALU_W-1:0];
  assign res.lt   = full[ALU_W];

endmodule

// ===== src/pcpa_link_ram.sv =====
module pcpa_link_ram #(
  parameter int DEPTH = 32768,
  parameter int AW    = 15,
  parameter int DW    = 21
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/per_cpu_page_frame_allocator.sv =====
// Per-CPU page-frame allocator with one LIFO free list per CPU.
// in_ch carries requests: action (allocate or free), cpu and page_addr.
// out_ch returns one transaction per request: alloc_addr, status, source_cpu.
// cfg_ch writes low_limit (index 0) and high_limit (index 1); it is always ready
// and must only be used while no request is in flight.
// A request is taken only while the sequencer is idle. Compares and the final
// remainder subtract run through one shared subtractor, and one shared
// multiplier forms the page modulo NUM_PAGES by reciprocal multiplication
// (quotient multiply, back multiply, subtract).
// A free walks four range compares, the modulo and one link write, then hands
// its result to the output register. An allocate loads the list head, runs the
// same modulo, reads the link memory (registered read) and pops. Requests
// rejected at once (bad cpu, misaligned, out of memory) go straight from idle to
// the result; a free rejected by a range compare skips the remaining compares,
// the modulo and the link write. The next request is taken only after the
// result has moved to the output register.
// The result sits in an output register; a new request is accepted while it
// waits, and the next result holds in the sequencer until out_ch.ready frees it.
// Synchronous reset empties every list and restores the limit registers; the
// link memory is not cleared, since a link is only read after it was written.
// PAGE_BYTES must be a power of two.
module per_cpu_page_frame_allocator import pcpa_pkg::*; #(
  parameter int NUM_CPUS   = 8,
  parameter int NUM_PAGES  = 32768,
  parameter int PAGE_BYTES = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  pcpa_req_if.sink   in_ch,
  pcpa_rsp_if.source out_ch,
  pcpa_cfg_if.sink   cfg_ch
);

  localparam int OFF_W  = $clog2(PAGE_BYTES);
  localparam int PAGE_W = ADDR_W - OFF_W;
  localparam int LINK_W = PAGE_W + 1;
  localparam int SLOT_W = $clog2(NUM_PAGES);
  localparam int CPU_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int MUL_W  = PAGE_W + 1;
  localparam int PROD_W = 2 * MUL_W;
  localparam int RCP_SH = PAGE_W + SLOT_W;

  // rounded-up reciprocal of NUM_PAGES, exact quotient for every page number
  localparam longint unsigned RCP_FULL =
    ((64'd1 << RCP_SH) + 64'(NUM_PAGES) - 64'd1) / 64'(NUM_PAGES);
  localparam logic [MUL_W-1:0] RCP = MUL_W'(RCP_FULL);

  typedef enum logic [3:0] {
    IDLE, CHK_LO, CHK_HI, CHK_BASE, CHK_WIN, ALOAD, MULQ, MULR, MSUB, WR, RD, POP, FIN
  } state_t;

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   low_limit_r, low_limit_nxt;
  logic [ADDR_W-1:0]   high_limit_r, high_limit_nxt;
  logic [PAGE_W-1:0]   head_page_r [NUM_CPUS];
  logic [PAGE_W-1:0]   head_page_nxt [NUM_CPUS];
  logic [NUM_CPUS-1:0] head_valid_r, head_valid_nxt;
  logic                act_r, act_nxt;
  logic [CPU_W-1:0]    cur_r, cur_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic [PAGE_W-1:0]   diff_r, diff_nxt;
  logic [PAGE_W-1:0]   div_r, div_nxt;
  logic [SLOT_W-1:0]   rem_r, rem_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [ADDR_W-1:0]   res_addr_r, res_addr_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [CPU_F_W-1:0]  res_src_r, res_src_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]   out_addr_r, out_addr_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [CPU_F_W-1:0]  out_src_r, out_src_nxt;

  logic [ALU_W-1:0]    opa, opb;
  alu_res_t            alu;
  logic [MUL_W-1:0]    mul_a, mul_b;
  logic [PROD_W-1:0]   prod;
  logic [PAGE_W-1:0]   quot;
  logic [PAGE_W-1:0]   page;
  logic [PAGE_W:0]     base;
  logic                ram_we, ram_re;
  logic [LINK_W-1:0]   ram_wdata, ram_rdata;
  logic [CPU_W-1:0]    cpu_idx, sel;
  logic                cpu_ok, any_valid;

  // request page number and first page of the table window
  assign page  = addr_r[ADDR_W-1:OFF_W];
  assign base  = {1'b0, low_limit_r[ADDR_W-1:OFF_W]}
               + (PAGE_W+1)'(|low_limit_r[OFF_W-1:0]);

  assign cpu_idx = CPU_W'(in_ch.cpu);
  assign cpu_ok  = (32'(in_ch.cpu) < NUM_CPUS);

  // list chosen for an allocate: own list first, else lowest non-empty
  always_comb begin
    sel       = '0;
    any_valid = 1'b0;
    for (int i = NUM_CPUS - 1; i >= 0; i--) begin
      if (head_valid_r[i]) begin
        sel       = CPU_W'(i);
        any_valid = 1'b1;
      end
    end
    if (cpu_ok && head_valid_r[cpu_idx]) begin
      sel = cpu_idx;
    end
  end

  // shared subtractor operand select
  always_comb begin
    opa = '0;
    opb = '0;
    case (state_r)
      CHK_LO: begin
        opa = addr_r;
        opb = low_limit_r;
      end
      CHK_HI: begin
        opa = addr_r;
        opb = high_limit_r;
      end
      CHK_BASE: begin
        opa = ALU_W'(page);
        opb = ALU_W'(base);
      end
      CHK_WIN: begin
        opa = ALU_W'(diff_r);
        opb = ALU_W'(NUM_PAGES);
      end
      MSUB: begin
        opa = ALU_W'(div_r);
        opb = ALU_W'(prod_r);
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  pcpa_alu u_alu (
    .opa (opa),
    .opb (opb),
    .res (alu)
  );

  // shared multiplier: page times reciprocal, then quotient times NUM_PAGES
  assign quot = PAGE_W'(prod_r >> RCP_SH);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      MULQ: begin
        mul_a = MUL_W'(div_r);
        mul_b = RCP;
      end
      MULR: begin
        mul_a = MUL_W'(quot);
        mul_b = MUL_W'(NUM_PAGES);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  // link entry: bit 0 valid, upper bits the page below in the list
  assign ram_we    = (state_r == WR);
  assign ram_re    = (state_r == RD);
  assign ram_wdata = head_valid_r[cur_r] ? {head_page_r[cur_r], 1'b1} : '0;

  pcpa_link_ram #(
    .DEPTH (NUM_PAGES),
    .AW    (SLOT_W),
    .DW    (LINK_W)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (rem_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rem_r),
    .rdata (ram_rdata)
  );

  // sequencer next state
  always_comb begin
    state_nxt      = state_r;
    low_limit_nxt  = low_limit_r;
    high_limit_nxt = high_limit_r;
    head_page_nxt  = head_page_r;
    head_valid_nxt = head_valid_r;
    act_nxt        = act_r;
    cur_nxt        = cur_r;
    addr_nxt       = addr_r;
    diff_nxt       = diff_r;
    div_nxt        = div_r;
    rem_nxt        = rem_r;
    prod_nxt       = prod_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    res_src_nxt    = res_src_r;
    out_valid_nxt  = out_valid_r;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;
    out_src_nxt    = out_src_r;

    // configuration write
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_LOW_LIMIT:  low_limit_nxt  = cfg_ch.data;
        CFG_HIGH_LIMIT: high_limit_nxt = cfg_ch.data;
        default:        low_limit_nxt  = low_limit_r;
      endcase
    end

    // output transaction taken
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      IDLE: begin
        if (in_ch.valid) begin
          act_nxt        = in_ch.action;
          addr_nxt       = in_ch.page_addr;
          res_addr_nxt   = '0;
          res_src_nxt    = '0;
          res_status_nxt = ST_OK;
          if (in_ch.action == ACT_FREE) begin
            cur_nxt = cpu_idx;
            if (!cpu_ok || (|in_ch.page_addr[OFF_W-1:0])) begin
              res_status_nxt = ST_BAD;
              state_nxt      = FIN;
            end else begin
              state_nxt = CHK_LO;
            end
          end else begin
            cur_nxt = sel;
            if (!any_valid) begin
              res_status_nxt = ST_OOM;
              state_nxt      = FIN;
            end else begin
              state_nxt = ALOAD;
            end
          end
        end
      end
      CHK_LO: begin
        if (alu.lt) begin
          res_status_nxt = ST_BAD;
          state_nxt      = FIN;
        end else begin
          state_nxt = CHK_HI;
        end
      end
      CHK_HI: begin
        if (!alu.lt) begin
          res_status_nxt = ST_BAD;
          state_nxt      = FIN;
        end else begin
          state_nxt = CHK_BASE;
        end
      end
      CHK_BASE: begin
        diff_nxt = alu.diff[PAGE_W-1:0];
        if (alu.lt) begin
          res_status_nxt = ST_BAD;
          state_nxt      = FIN;
        end else begin
          state_nxt = CHK_WIN;
        end
      end
      CHK_WIN: begin
        if (!alu.lt) begin
          res_status_nxt = ST_BAD;
          state_nxt      = FIN;
        end else begin
          div_nxt   = page;
          state_nxt = MULQ;
        end
      end
      ALOAD: begin
        div_nxt   = head_page_r[cur_r];
        state_nxt = MULQ;
      end
      MULQ: begin
        prod_nxt  = prod;
        state_nxt = MULR;
      end
      MULR: begin
        prod_nxt  = prod;
        state_nxt = MSUB;
      end
      MSUB: begin
        // page minus quotient times NUM_PAGES gives the table slot
        rem_nxt   = alu.diff[SLOT_W-1:0];
        state_nxt = (act_r == ACT_FREE) ? WR : RD;
      end
      WR: begin
        head_page_nxt[cur_r]  = page;
        head_valid_nxt[cur_r] = 1'b1;
        state_nxt             = FIN;
      end
      RD: begin
        state_nxt = POP;
      end
      POP: begin
        head_valid_nxt[cur_r] = ram_rdata[0];
        head_page_nxt[cur_r]  = ram_rdata[0] ? ram_rdata[LINK_W-1:1] : '0;
        res_addr_nxt          = {div_r, {OFF_W{1'b0}}};
        res_src_nxt           = CPU_F_W'(cur_r);
        state_nxt             = FIN;
      end
      FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = res_addr_r;
          out_status_nxt = res_status_r;
          out_src_nxt    = res_src_r;
          state_nxt      = IDLE;
        end
      end
      default: begin
        state_nxt = IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= IDLE;
      low_limit_r  <= LOW_LIMIT_RST;
      high_limit_r <= HIGH_LIMIT_RST;
      head_valid_r <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < NUM_CPUS; i++) begin
        head_page_r[i] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      low_limit_r  <= low_limit_nxt;
      high_limit_r <= high_limit_nxt;
      head_valid_r <= head_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      head_page_r  <= head_page_nxt;
    end
    act_r        <= act_nxt;
    cur_r        <= cur_nxt;
    addr_r       <= addr_nxt;
    diff_r       <= diff_nxt;
    div_r        <= div_nxt;
    rem_r        <= rem_nxt;
    prod_r       <= prod_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
    res_src_r    <= res_src_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
    out_src_r    <= out_src_nxt;
  end

  assign in_ch.ready       = (state_r == IDLE);
  assign cfg_ch.ready      = 1'b1;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.alloc_addr = out_addr_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.source_cpu = out_src_r;

endmodule
